[design/websocket_frame_deframer_core_macros.svh]
// Assertion macros for the websocket frame deframer core.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active low reset).
`define WFD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WFD_ASSERT(label, clk, rstn, prop, msg)

`define WFD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[design/wsdefr_pkg.sv]
// Types and constants for the websocket frame deframer core.
package wsdefr_pkg;

    typedef enum logic [2:0] {
        PH_B0   = 3'd0,
        PH_B1   = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_16    = 2'd1,
        LEN_64    = 2'd2
    } len_form_t;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_FRAG_CTRL   = 3'd1;
    localparam logic [2:0] ERR_ORPHAN_CONT = 3'd2;
    localparam logic [2:0] ERR_UNMASKED    = 3'd3;
    localparam logic [2:0] ERR_NONMINIMAL  = 3'd4;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Header byte counts at which each header part ends.
    localparam logic [3:0] HDR_EXT16_END = 4'd4;
    localparam logic [3:0] HDR_EXT64_END = 4'd10;
    localparam logic [3:0] HDR_SHORT_END = 4'd6;
    localparam logic [3:0] HDR_16_END    = 4'd8;
    localparam logic [3:0] HDR_64_END    = 4'd14;

endpackage

[design/websocket_frame_deframer_core.sv]
// WebSocket client-to-server frame deframer: header parse, unmasking, fragment tracking.
//
// Usage:
//   Input channel (s_valid/s_ready/s_rx_byte) carries the received byte
//   stream, one byte per item. Every accepted item yields exactly one result
//   item on the m_ channel: a header byte note, a data payload byte
//   (unmasked), a consumed control payload byte, or a protocol error.
//   The result is registered and valid in the cycle after its item is
//   accepted. Throughput is one item per cycle unless the result stalls;
//   the only per-item work is a header field update or a key XOR, all
//   settled between the parser state registers and the result register.
//   A stalled receiver (m_ready low with a result pending) holds the result
//   register and drops s_ready; as soon as the result is taken a new item is
//   accepted in the same cycle, so no bubble is added.
//   An error result clears all parser state including the open fragmented
//   message; the next byte starts a new frame.
//   Reset (aresetn low, synchronous) empties the result register and
//   returns the parser to "expect first header byte" with no open message.
//   Payload length is tracked as a 64-bit remaining count, so frames of any
//   encoded length are handled.
module websocket_frame_deframer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_payload_byte,
    output logic [3:0] m_frame_opcode,
    output logic       m_fin_flag,
    output logic       m_frame_end,
    output logic       m_close_received,
    output logic [2:0] m_error_code
);
    import wsdefr_pkg::*;

    `include "websocket_frame_deframer_core_macros.svh"

    // Parser state
    phase_t    phase_reg, phase_next;
    len_form_t form_reg, form_next;
    logic [3:0]  hbc_reg, hbc_next;        // header bytes seen in this frame
    logic [3:0]  op_reg, op_next;          // effective opcode of current frame
    logic        fin_reg, fin_next;
    logic [63:0] len_reg, len_next;        // length; counts down in payload
    logic [31:0] key_reg, key_next;        // first key byte lands in [31:24]
    logic [1:0]  kidx_reg, kidx_next;      // payload index mod 4
    logic [3:0]  frag_op_reg, frag_op_next;
    logic        frag_valid_reg, frag_valid_next;

    // Result register
    logic       m_valid_reg;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] pb_reg, pb_next;
    logic [3:0] rop_reg, rop_next;
    logic       rfin_reg, rfin_next;
    logic       rend_reg, rend_next;
    logic       rclose_reg, rclose_next;
    logic [2:0] rerr_reg, rerr_next;

    logic       s_fire;
    logic       ctl;
    logic [3:0] hbc_inc;
    logic       ext_done;
    logic       mask_done;
    logic [2:0] err_code;
    logic       frame_done;
    logic [3:0] op_eff;
    logic       fin_eff;
    logic [7:0] key_byte;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // ---------------------------------------------------------------
    // Decode of the current byte against parser state
    // ---------------------------------------------------------------
    always_comb begin
        ctl       = op_reg[3];
        hbc_inc   = hbc_reg + 4'd1;
        ext_done  = (hbc_inc >= ((form_reg == LEN_16) ? HDR_EXT16_END : HDR_EXT64_END));
        mask_done = (hbc_inc >= ((form_reg == LEN_16) ? HDR_16_END :
                                 (form_reg == LEN_64) ? HDR_64_END : HDR_SHORT_END));
        err_code   = ERR_NONE;
        frame_done = 1'b0;
        case (phase_reg)
            PH_B1: begin
                if (ctl && !fin_reg) begin
                    err_code = ERR_FRAG_CTRL;
                end else if (!ctl && op_reg == OP_CONT && !frag_valid_reg) begin
                    err_code = ERR_ORPHAN_CONT;
                end else if (!s_rx_byte[7]) begin
                    err_code = ERR_UNMASKED;
                end
            end
            PH_MASK: begin
                if (mask_done) begin
                    if ((form_reg == LEN_16 && len_reg < 64'd126) ||
                        (form_reg == LEN_64 && len_reg[63:16] == 48'd0)) begin
                        err_code = ERR_NONMINIMAL;
                    end else if (len_reg == 64'd0) begin
                        frame_done = 1'b1;
                    end
                end
            end
            PH_PAY: begin
                frame_done = (len_reg == 64'd1);
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Next phase
    // ---------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        if (err_code != ERR_NONE || frame_done) begin
            phase_next = PH_B0;
        end else begin
            case (phase_reg)
                PH_B0:   phase_next = PH_B1;
                PH_B1:   phase_next = (s_rx_byte[6:0] < LEN_CODE_16) ? PH_MASK : PH_EXT;
                PH_EXT:  phase_next = ext_done ? PH_MASK : PH_EXT;
                PH_MASK: phase_next = mask_done ? PH_PAY : PH_MASK;
                PH_PAY:  phase_next = PH_PAY;
                default: phase_next = PH_B0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath and result
    // ---------------------------------------------------------------
    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        form_next       = form_reg;
        hbc_next        = hbc_reg;
        op_next         = op_reg;
        fin_next        = fin_reg;
        len_next        = len_reg;
        key_next        = key_reg;
        kidx_next       = kidx_reg;
        frag_op_next    = frag_op_reg;
        frag_valid_next = frag_valid_reg;
        kind_next       = KIND_HEADER;
        pb_next         = 8'd0;

        case (phase_reg)
            PH_B1: begin
                hbc_next = 4'd2;
                if (!ctl) begin
                    if (op_reg == OP_CONT) begin
                        op_next = frag_op_reg;
                    end else if (!fin_reg) begin
                        frag_op_next    = op_reg;
                        frag_valid_next = 1'b1;
                    end else begin
                        frag_op_next    = OP_CONT;
                        frag_valid_next = 1'b0;
                    end
                end
                if (s_rx_byte[6:0] < LEN_CODE_16) begin
                    len_next  = {57'd0, s_rx_byte[6:0]};
                    form_next = LEN_SHORT;
                end else begin
                    len_next  = 64'd0;
                    form_next = (s_rx_byte[6:0] == LEN_CODE_64) ? LEN_64 : LEN_16;
                end
            end
            PH_EXT: begin
                len_next = {len_reg[55:0], s_rx_byte};
                hbc_next = hbc_inc;
            end
            PH_MASK: begin
                key_next  = {key_reg[23:0], s_rx_byte};
                hbc_next  = hbc_inc;
                kidx_next = 2'd0;
            end
            PH_PAY: begin
                pb_next   = s_rx_byte ^ key_byte;
                kind_next = ctl ? KIND_CONTROL : KIND_DATA;
                kidx_next = kidx_reg + 2'd1;
                len_next  = len_reg - 64'd1;
            end
            default: begin
                op_next  = s_rx_byte[3:0];
                fin_next = s_rx_byte[7];
                hbc_next = 4'd1;
            end
        endcase

        op_eff  = op_next;
        fin_eff = fin_next;

        rop_next    = op_eff;
        rfin_next   = fin_eff;
        rend_next   = frame_done;
        rclose_next = frame_done && (op_eff == OP_CLOSE);
        rerr_next   = ERR_NONE;

        if (frame_done && fin_eff && !op_eff[3]) begin
            frag_op_next    = OP_CONT;
            frag_valid_next = 1'b0;
        end

        if (err_code != ERR_NONE) begin
            kind_next       = KIND_ERROR;
            pb_next         = 8'd0;
            rop_next        = 4'd0;
            rfin_next       = 1'b0;
            rend_next       = 1'b0;
            rclose_next     = 1'b0;
            rerr_next       = err_code;
            frag_op_next    = OP_CONT;
            frag_valid_next = 1'b0;
        end

        // End of frame or error: drop all per-frame state.
        if (err_code != ERR_NONE || frame_done) begin
            form_next = LEN_SHORT;
            hbc_next  = 4'd0;
            op_next   = OP_CONT;
            fin_next  = 1'b0;
            len_next  = 64'd0;
            key_next  = 32'd0;
            kidx_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_B0;
            form_reg       <= LEN_SHORT;
            hbc_reg        <= 4'd0;
            op_reg         <= OP_CONT;
            fin_reg        <= 1'b0;
            len_reg        <= 64'd0;
            key_reg        <= 32'd0;
            kidx_reg       <= 2'd0;
            frag_op_reg    <= OP_CONT;
            frag_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg      <= phase_next;
                form_reg       <= form_next;
                hbc_reg        <= hbc_next;
                op_reg         <= op_next;
                fin_reg        <= fin_next;
                len_reg        <= len_next;
                key_reg        <= key_next;
                kidx_reg       <= kidx_next;
                frag_op_reg    <= frag_op_next;
                frag_valid_reg <= frag_valid_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on every accepted item.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg   <= kind_next;
            pb_reg     <= pb_next;
            rop_reg    <= rop_next;
            rfin_reg   <= rfin_next;
            rend_reg   <= rend_next;
            rclose_reg <= rclose_next;
            rerr_reg   <= rerr_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_payload_byte   = pb_reg;
    assign m_frame_opcode   = rop_reg;
    assign m_fin_flag       = rfin_reg;
    assign m_frame_end      = rend_reg;
    assign m_close_received = rclose_reg;
    assign m_error_code     = rerr_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `WFD_ASSERT(a_err_clears_state, aclk, aresetn,
        s_fire && err_code != ERR_NONE |=> phase_reg == PH_B0 && !frag_valid_reg,
        "error did not clear parser state")

    `WFD_ASSERT(a_close_needs_end, aclk, aresetn,
        m_valid && m_close_received |-> m_frame_end && m_frame_opcode == OP_CLOSE,
        "close flagged without close frame end")

    `WFD_ASSERT(a_payload_len_nonzero, aclk, aresetn,
        phase_reg == PH_PAY |-> len_reg != 64'd0,
        "payload phase with no bytes left")

    `WFD_ASSERT(a_stall_blocks_input, aclk, aresetn,
        m_valid && !m_ready |-> !s_ready,
        "input taken while result stalled")

    `WFD_ASSERT(a_err_kind_match, aclk, aresetn,
        m_valid |-> ((m_kind == KIND_ERROR) == (m_error_code != ERR_NONE)),
        "error kind and error code disagree")

endmodule
